// ----- rtl/tsk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsk_pkg: shared types and constants of the top-k smallest keeper
// Item layouts, function codes, controller states and the result record.
// ----------------------------------------------------------------------------
package tsk_pkg;

  localparam int unsigned ScoreW = 32;
  localparam int unsigned PosW   = 32;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned KeepW  = 7;

  // s_axis_tdata: score, position, read_slot, zero fill to whole bytes
  localparam int unsigned InW  = 72;
  // m_axis_tdata: six result fields, zero fill to whole bytes
  localparam int unsigned OutW = 104;

  localparam logic [ScoreW-1:0] ThrNotFull = '1;

  localparam logic [KeepW-1:0] KeepReset = 7'd64;

  typedef enum logic {
    FUNC_OFFER = 1'b0,
    FUNC_READ  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              accepted;
    logic              full_res;
    logic [ScoreW-1:0] threshold;
    logic              entry_valid;
    logic [ScoreW-1:0] entry_score;
    logic [PosW-1:0]   entry_position;
  } res_t;

endpackage

// ----- rtl/top_k_smallest_keeper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_smallest_keeper: bounded store of the smallest-score entries
// Holds (score, position) entries in two memories with a registered read
// port, appends only while below keep_count, tracks the largest held score
// and its lowest slot, and answers offer and read items with one result each.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/tready        tdata: score, position,
//                                                   read_slot; tuser: func
//  m_axis    out        m_axis_tvalid/tready        tdata: six result fields
//  keep cfg  in         keep_count_we_i (no wait)   keep_count_i
//
//  Steps: a rejected or appended offer goes straight to the hand-off state,
//  a read waits in ST_RD_WAIT for the registered memory data, and a
//  replacing offer rescans every held slot through the memory read port
//  once, one slot per cycle, to find the new largest score. Reset clears
//  the fill count, not the slot memories; a read at or above the fill is
//  masked to zero. One item is in work at a time; a finished result waits
//  in the output register while the next item is taken and worked on, and
//  only the final hand-off stalls on m_axis_tready.
//
module top_k_smallest_keeper
  import tsk_pkg::*;
#(
  parameter int unsigned MAX_KEEP = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // keep_count register write
  input  logic             keep_count_we_i,
  input  logic [KeepW-1:0] keep_count_i,
  // input items
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [InW-1:0]   s_axis_tdata,  // [31:0] score, [63:32] position,
                                          // [69:64] read_slot, [71:70] zero
  input  logic             s_axis_tuser,  // [0] func
  // result items
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OutW-1:0]  m_axis_tdata   // [0] accepted, [1] full_res,
                                          // [33:2] threshold, [34] entry_valid,
                                          // [66:35] entry_score,
                                          // [98:67] entry_position, [103:99] 0
);

  // Slot address, fill count and compare widths
  localparam int unsigned AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int unsigned FW = $clog2(MAX_KEEP + 1);
  localparam int unsigned CW = (FW > KeepW) ? FW : KeepW;

  // Slot memories
  logic [ScoreW-1:0] mem_score [MAX_KEEP];
  logic [PosW-1:0]   mem_pos   [MAX_KEEP];

  state_e            state_q, state_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [KeepW-1:0]  keep_q;
  logic [ScoreW-1:0] max_val_q, max_val_d;
  logic [AW-1:0]     max_idx_q, max_idx_d;
  logic [FW-1:0]     scan_addr_q, scan_addr_d;
  logic              scan_vld_q, scan_vld_d;
  logic [AW-1:0]     scan_idx_q, scan_idx_d;
  res_t              res_q, res_d;
  logic              out_vld_q, out_vld_d;
  logic [OutW-1:0]   out_data_q, out_data_d;
  logic [ScoreW-1:0] rd_score_q;
  logic [PosW-1:0]   rd_pos_q;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [ScoreW-1:0] wr_score;
  logic [PosW-1:0]   wr_pos;

  logic              in_fire;
  func_e             in_func;
  logic [ScoreW-1:0] in_score;
  logic [PosW-1:0]   in_pos;
  logic [SlotW-1:0]  in_slot;

  logic [CW-1:0]     keep_w;
  logic [CW-1:0]     eff_keep;
  logic [CW-1:0]     fill_w;
  logic [CW-1:0]     slot_w;
  logic              full_now;
  logic              full_after_add;
  logic [ScoreW-1:0] thr_now;
  logic [ScoreW-1:0] add_max_val;
  logic [AW-1:0]     add_max_idx;
  logic [ScoreW-1:0] scan_val;
  logic [AW-1:0]     scan_best;
  logic              scan_last;
  logic              out_load;

  // Unpack the input item
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign in_func  = func_e'(s_axis_tuser);
  assign in_score = s_axis_tdata[31:0];
  assign in_pos   = s_axis_tdata[63:32];
  assign in_slot  = s_axis_tdata[69:64];

  // Clamp keep_count: zero acts as one, anything above MAX_KEEP as MAX_KEEP
  assign keep_w   = CW'(keep_q);
  assign eff_keep = (keep_w == '0)                ? CW'(1) :
                    (keep_w > CW'(MAX_KEEP))      ? CW'(MAX_KEEP) : keep_w;
  assign fill_w   = CW'(fill_q);
  assign slot_w   = CW'(in_slot);
  assign full_now = (fill_w >= eff_keep);
  assign full_after_add = ((fill_w + CW'(1)) >= eff_keep);

  // max_val_q/max_idx_q track the largest held score (lowest slot) outside a rescan
  assign thr_now = full_now ? max_val_q : ThrNotFull;

  // Running maximum after an append; strict compare keeps the lowest slot
  assign add_max_val = ((fill_q == '0) || (in_score > max_val_q)) ? in_score : max_val_q;
  assign add_max_idx = ((fill_q == '0) || (in_score > max_val_q)) ? fill_q[AW-1:0]
                                                                  : max_idx_q;

  // Rescan step: slot 0 seeds the maximum, later slots replace it if larger
  assign scan_val  = ((scan_idx_q == '0) || (rd_score_q > max_val_q)) ? rd_score_q
                                                                      : max_val_q;
  assign scan_best = ((scan_idx_q == '0) || (rd_score_q > max_val_q)) ? scan_idx_q
                                                                      : max_idx_q;
  assign scan_last = scan_vld_q && (FW'(scan_idx_q) == (fill_q - FW'(1)));

  assign out_load = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

  // Next state, memory port control and result assembly
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    max_val_d   = max_val_q;
    max_idx_d   = max_idx_q;
    scan_addr_d = scan_addr_q;
    scan_vld_d  = 1'b0;
    scan_idx_d  = scan_idx_q;
    res_d       = res_q;
    rd_en       = 1'b0;
    rd_addr     = slot_w[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = fill_q[AW-1:0];
    wr_score    = in_score;
    wr_pos      = in_pos;
    s_axis_tready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_d             = '0;
          res_d.full_res    = full_now;
          res_d.threshold   = thr_now;
          if (in_func == FUNC_READ) begin
            // Read the slot; mask it later if it lies at or above the fill
            rd_en             = 1'b1;
            res_d.entry_valid = (slot_w < fill_w);
            state_d           = ST_RD_WAIT;
          end else if (!full_now) begin
            // Append to the next free slot
            wr_en          = 1'b1;
            fill_d         = fill_q + FW'(1);
            max_val_d      = add_max_val;
            max_idx_d      = add_max_idx;
            res_d.accepted = 1'b1;
            res_d.full_res = full_after_add;
            res_d.threshold = full_after_add ? add_max_val : ThrNotFull;
            state_d        = ST_DONE;
          end else if (in_score < max_val_q) begin
            // Overwrite the largest entry, then rescan for the new maximum
            wr_en          = 1'b1;
            wr_addr        = max_idx_q;
            res_d.accepted = 1'b1;
            scan_addr_d    = '0;
            state_d        = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_RD_WAIT: begin
        res_d.entry_score    = res_q.entry_valid ? rd_score_q : '0;
        res_d.entry_position = res_q.entry_valid ? rd_pos_q : '0;
        state_d              = ST_DONE;
      end
      ST_SCAN: begin
        if (scan_addr_q < fill_q) begin
          rd_en       = 1'b1;
          rd_addr     = scan_addr_q[AW-1:0];
          scan_addr_d = scan_addr_q + FW'(1);
          scan_vld_d  = 1'b1;
          scan_idx_d  = scan_addr_q[AW-1:0];
        end
        if (scan_vld_q) begin
          max_val_d = scan_val;
          max_idx_d = scan_best;
        end
        if (scan_last) begin
          res_d.threshold = scan_val;
          state_d         = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Output register: load a finished result, drop it once taken
    out_data_d = out_data_q;
    out_vld_d  = out_vld_q;
    if (out_load) begin
      out_vld_d  = 1'b1;
      out_data_d = {5'b0, res_q.entry_position, res_q.entry_score, res_q.entry_valid,
                    res_q.threshold, res_q.full_res, res_q.accepted};
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      keep_q     <= KeepReset;
      scan_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      scan_vld_q <= scan_vld_d;
      out_vld_q  <= out_vld_d;
      if (keep_count_we_i) begin
        keep_q <= keep_count_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    max_val_q   <= max_val_d;
    max_idx_q   <= max_idx_d;
    scan_addr_q <= scan_addr_d;
    scan_idx_q  <= scan_idx_d;
    res_q       <= res_d;
    out_data_q  <= out_data_d;
  end

  // Slot memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_score[wr_addr] <= wr_score;
      mem_pos[wr_addr]   <= wr_pos;
    end
    if (rd_en) begin
      rd_score_q <= mem_score[rd_addr];
      rd_pos_q   <= mem_pos[rd_addr];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // The fill count never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(MAX_KEEP))
    else $error("fill count above store depth");

  // A rescan only runs over a nonempty store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (fill_q != '0))
    else $error("rescan over an empty store");

  // A new result appears only out of the hand-off state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == ST_DONE))
    else $error("result loaded outside hand-off");

  // A stored offer never carries read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_data_q[0]) |-> !out_data_q[34])
    else $error("accepted offer flagged as read");

endmodule

// ----- tb/tsk_keeper_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsk_keeper_monitor: result predictor and checker of the top-k keeper
// Watches the keep_count writes and both item channels, keeps its own copy of
// the store, works out the result of every accepted input item and compares
// each result item, field by field, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module tsk_keeper_monitor
  import tsk_pkg::*;
#(
  parameter int unsigned MAX_KEEP = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             keep_count_we_i,
  input  logic [KeepW-1:0] keep_count_i,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [InW-1:0]   s_axis_tdata,
  input  logic             s_axis_tuser,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [OutW-1:0]  m_axis_tdata,
  output int unsigned      outstanding_o,
  output int unsigned      fail_count_o
);

  typedef struct {
    logic              accepted;
    logic              full_res;
    logic [ScoreW-1:0] threshold;
    logic              entry_valid;
    logic [ScoreW-1:0] entry_score;
    logic [PosW-1:0]   entry_position;
  } outcome_t;

  logic [ScoreW-1:0] held_score [MAX_KEEP];
  logic [PosW-1:0]   held_pos   [MAX_KEEP];
  int unsigned       fill;
  logic [KeepW-1:0]  keep_reg;
  outcome_t          pending_outcomes [$];
  int unsigned       fail_count;
  int unsigned       result_count;

  assign fail_count_o = fail_count;

  // Zero acts as one, anything above the store size as the store size.
  function automatic int unsigned keep_limit();
    if (keep_reg == '0) return 1;
    if (keep_reg > MAX_KEEP) return MAX_KEEP;
    return 32'(keep_reg);
  endfunction

  function automatic bit store_full();
    return fill >= keep_limit();
  endfunction

  // Lowest slot holding the largest score.
  function automatic int unsigned largest_slot();
    int unsigned best = 0;
    for (int unsigned i = 1; i < fill; i++) begin
      if (held_score[i] > held_score[best]) best = i;
    end
    return best;
  endfunction

  function automatic logic [ScoreW-1:0] threshold_now();
    if (!store_full() || fill == 0) return ThrNotFull;
    return held_score[largest_slot()];
  endfunction

  // Apply one input item to the store and return the result it causes.
  function automatic outcome_t predict_outcome(func_e func, logic [ScoreW-1:0] score,
                                               logic [PosW-1:0] pos,
                                               logic [SlotW-1:0] slot);
    outcome_t    res;
    int unsigned victim;
    res = '{default: '0};
    if (func == FUNC_OFFER) begin
      if (!store_full()) begin
        if (fill < MAX_KEEP) begin
          held_score[fill] = score;
          held_pos[fill]   = pos;
          fill++;
          res.accepted = 1'b1;
        end
      end else if (fill > 0) begin
        victim = largest_slot();
        if (score < held_score[victim]) begin
          held_score[victim] = score;
          held_pos[victim]   = pos;
          res.accepted       = 1'b1;
        end
      end
    end else if (slot < fill) begin
      res.entry_valid    = 1'b1;
      res.entry_score    = held_score[slot];
      res.entry_position = held_pos[slot];
    end
    res.full_res  = store_full();
    res.threshold = threshold_now();
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t ns: result %0d, %s: got %h, want %h", $realtime, result_count, what, got,
               want);
    end
  endtask

  task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : p_watch
    outcome_t got;
    outcome_t want;
    if (!rst_ni) begin
      fill          = 0;
      keep_reg      = KeepReset;
      pending_outcomes.delete();
      outstanding_o <= 0;
    end else begin
      if (keep_count_we_i) keep_reg = keep_count_i;
      if (s_axis_tvalid && s_axis_tready) begin
        pending_outcomes.push_back(predict_outcome(func_e'(s_axis_tuser), s_axis_tdata[31:0],
                                                   s_axis_tdata[63:32], s_axis_tdata[69:64]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.accepted       = m_axis_tdata[0];
        got.full_res       = m_axis_tdata[1];
        got.threshold      = m_axis_tdata[33:2];
        got.entry_valid    = m_axis_tdata[34];
        got.entry_score    = m_axis_tdata[66:35];
        got.entry_position = m_axis_tdata[98:67];
        result_count++;
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result with nothing outstanding", m_axis_tdata[31:0], '0);
        end else begin
          want = pending_outcomes.pop_front();
          compare_field("accepted", got.accepted, want.accepted);
          compare_field("full_res", got.full_res, want.full_res);
          compare_field("threshold", got.threshold, want.threshold);
          compare_field("entry_valid", got.entry_valid, want.entry_valid);
          compare_field("entry_score", got.entry_score, want.entry_score);
          compare_field("entry_position", got.entry_position, want.entry_position);
        end
      end
      outstanding_o <= pending_outcomes.size();
    end
  end

endmodule

// ----- tb/tb_top_k_smallest_keeper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_k_smallest_keeper: stimulus and verdict for the top-k keeper
// Drives a directed run over the corner cases and then phases of random offer
// and read items under several keep_count settings; a monitor beside the
// block predicts every result and counts the mismatches.
// ----------------------------------------------------------------------------
module tb_top_k_smallest_keeper;
  import tsk_pkg::*;

  // Quiet cycles tolerated before giving up: a replacement rescans every held
  // slot, plus random stalls on both sides, so this leaves a wide margin.
  localparam int unsigned StallLimit  = 2000;
  // Cycles to watch for stray results once nothing is outstanding.
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned NumPhases   = 7;

  logic             clk_i;
  logic             rst_ni;
  logic             keep_count_we_i;
  logic [KeepW-1:0] keep_count_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [InW-1:0]   s_axis_tdata;   // [31:0] score, [63:32] position,
                                    // [69:64] read_slot, [71:70] zero
  logic             s_axis_tuser;   // [0] func
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OutW-1:0]  m_axis_tdata;   // [0] accepted, [1] full_res,
                                    // [33:2] threshold, [34] entry_valid,
                                    // [66:35] entry_score,
                                    // [98:67] entry_position, [103:99] zero

  int unsigned outstanding;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  bit          steady;             // set: neither side idles

  // Random phases. keep_count walks through the extremes (0 is covered by the
  // directed part), falls below the fill three times, and score ceilings drop
  // from the third phase on so replacements go on as the held scores shrink.
  logic [KeepW-1:0]  phase_keep  [NumPhases] = '{7'd3, 7'd20, 7'd100, 7'd127, 7'd5,
                                                 7'd64, 7'd1};
  int unsigned       phase_items [NumPhases] = '{150, 200, 250, 200, 150, 200, 150};
  logic [ScoreW-1:0] phase_ceil  [NumPhases] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                                 32'h00FF_FFFF, 32'h0000_FFFF,
                                                 32'h0000_03FF, 32'h0000_003F,
                                                 32'h0000_0007};

  top_k_smallest_keeper i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .keep_count_we_i(keep_count_we_i),
    .keep_count_i   (keep_count_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata)
  );

  tsk_keeper_monitor i_keeper_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .keep_count_we_i(keep_count_we_i),
    .keep_count_i   (keep_count_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .outstanding_o  (outstanding),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: drop tready at random, with a chance of about 31 in 100, never while steady.
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 31);
  end

  // Watchdog: end the run when neither channel has moved an item for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item at a falling edge, hold it until the block takes it, and
  // return at the next falling edge with tvalid still high.
  task automatic send_item(func_e func, logic [ScoreW-1:0] score, logic [PosW-1:0] pos,
                           logic [SlotW-1:0] slot);
    if (!steady) begin
      while ($urandom_range(0, 99) < 31) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {2'b00, slot, pos, score};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic offer(logic [ScoreW-1:0] score, logic [PosW-1:0] pos);
    send_item(FUNC_OFFER, score, pos, SlotW'($urandom_range(0, 63)));
  endtask

  task automatic read_slot(logic [SlotW-1:0] slot);
    send_item(FUNC_READ, $urandom, $urandom, slot);
  endtask

  // Drop tvalid and hold until every outstanding result has come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // Write keep_count while the block is idle; one cycle of write enable.
  task automatic write_keep(logic [KeepW-1:0] value);
    keep_count_i    <= value;
    keep_count_we_i <= 1'b1;
    @(negedge clk_i);
    keep_count_we_i <= 1'b0;
  endtask

  // One random item: about a third are reads of any slot, the rest offers
  // whose scores mostly stay under the phase ceiling, with the ceiling and
  // zero themselves and a few full-range scores mixed in.
  task automatic random_item(logic [ScoreW-1:0] ceiling);
    logic [ScoreW-1:0] score;
    int unsigned       pick;
    if ($urandom_range(0, 99) < 30) begin
      read_slot(SlotW'($urandom_range(0, 63)));
    end else begin
      pick = $urandom_range(0, 9);
      if (pick == 0) score = $urandom_range(0, 1) ? ceiling : '0;
      else if (pick == 1) score = $urandom;
      else score = $urandom_range(0, ceiling);
      offer(score, $urandom);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    keep_count_we_i = 1'b0;
    keep_count_i    = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = 1'b0;
    m_axis_tready   = 1'b0;
    steady          = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // keep_count 0 acts as 1: the first offer fills the store, then only a
    // strictly smaller score replaces it; reads past the fill come back empty.
    write_keep(7'd0);
    offer(32'd5, 32'h0000_0000);
    offer(32'd5, 32'hFFFF_FFFF);
    offer(32'hFFFF_FFFF, 32'h1234_5678);
    offer(32'd3, 32'd1);
    offer(32'd0, 32'd2);
    read_slot(6'd0);
    read_slot(6'd1);
    read_slot(6'd63);
    settle();

    // Full with an all-ones score held: equal is refused, one below replaces.
    write_keep(7'd2);
    offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(32'hFFFF_FFFF, 32'hA5A5_A5A5);
    offer(32'hFFFF_FFFE, 32'd3);
    read_slot(6'd1);
    settle();

    // Tie on the largest score across three slots: the lowest one goes first.
    write_keep(7'd4);
    offer(32'd9, 32'd4);
    offer(32'd9, 32'd5);
    offer(32'd9, 32'd6);
    offer(32'd2, 32'd7);
    read_slot(6'd1);
    read_slot(6'd2);
    read_slot(6'd3);
    read_slot(6'd4);
    settle();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      write_keep(phase_keep[p]);
      steady = (p == 2);
      for (int unsigned n = 0; n < phase_items[p]; n++) random_item(phase_ceil[p]);
      settle();
    end
    steady = 1'b0;

    // Watch for stray results for longer than the slowest item takes.
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tsk_pkg.sv
rtl/top_k_smallest_keeper.sv
tb/tsk_keeper_monitor.sv
tb/tb_top_k_smallest_keeper.sv
